// ===== hw/rtl/gif_lzw_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// gif_lzw_decoder_defines.svh
// Assertion macros shared by the LZW decoder RTL.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_DECODER_DEFINES_SVH
`define GIF_LZW_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GLZW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GLZW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/glzw_pkg.sv =====
// ----------------------------------------------------------------------------
// glzw_pkg
// Constants, command/status types and helpers for the GIF LZW decoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_ENTRIES = 4096;
  localparam int TBL_AW        = 12;
  localparam int CODE_W        = 13;
  localparam logic [CODE_W-1:0] NO_CODE = 13'h1FFF;
  localparam int BUF_W         = 20;
  localparam int BCNT_W        = 5;
  localparam int NCNT_W        = 6;
  localparam logic [NCNT_W-1:0] MAX_PIX = 6'd63;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd1;

  localparam logic [1:0] ST_PIXEL  = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_BROKEN = 2'd2;

  typedef struct packed {
    logic byte_in;
    logic take_code;
    logic walk_rd;
    logic walk_dt;
    logic walk_end;
    logic pop_rd;
    logic pop_emit;
    logic stat_emit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic image_done;
    logic pop_ok;
    logic stop;
    logic code_clear;
    logic code_end;
    logic code_bad;
    logic walk_term;
    logic emit_ok;
    logic out_free;
    logic hold_valid;
    logic pend_nz;
  } sts_t;

  // clamp minimum code size to 1..8
  function automatic logic [3:0] eff_min(input logic [3:0] raw);
    logic [3:0] m;
    begin
      m = raw;
      if (m < 4'd1) m = 4'd1;
      if (m > 4'd8) m = 4'd8;
      return m;
    end
  endfunction

endpackage

// ===== hw/rtl/glzw_ctrl.sv =====
// ----------------------------------------------------------------------------
// glzw_ctrl
// Sequencer: byte intake, code decode loop, chain walk, pixel pops, results.
// ----------------------------------------------------------------------------
module glzw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  glzw_pkg::sts_t sts,
  output glzw_pkg::cmd_t cmd
);
  import glzw_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOP  = 4'd1;
  localparam logic [3:0] S_WRD   = 4'd2;
  localparam logic [3:0] S_WDT   = 4'd3;
  localparam logic [3:0] S_WEND  = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PEM   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.byte_in = 1'b1;
          if (!sts.image_done) state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.pop_ok) state_nxt = S_PRD;
        else if (sts.stop) state_nxt = S_FIN;
        else begin
          cmd.take_code = 1'b1;
          if (sts.code_clear) state_nxt = S_LOOP;
          else if (sts.code_end || sts.code_bad) state_nxt = S_FIN;
          else state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        cmd.walk_rd = 1'b1;
        state_nxt = sts.walk_term ? S_WEND : S_WDT;
      end
      S_WDT: begin
        cmd.walk_dt = 1'b1;
        state_nxt = S_WRD;
      end
      S_WEND: begin
        cmd.walk_end = 1'b1;
        state_nxt = S_LOOP;
      end
      S_PRD: begin
        cmd.pop_rd = 1'b1;
        state_nxt = S_PEM;
      end
      S_PEM: begin
        if (sts.emit_ok) begin
          cmd.pop_emit = 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_FIN: begin
        if (!sts.pend_nz) state_nxt = S_FLUSH;
        else if (sts.emit_ok) begin
          cmd.stat_emit = 1'b1;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.hold_valid) state_nxt = S_IDLE;
        else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== hw/rtl/glzw_datapath.sv =====
// ----------------------------------------------------------------------------
// glzw_datapath
// Bit buffer, code tables, pixel stack, column count and result staging.
// ----------------------------------------------------------------------------
module glzw_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [7:0]                          in_data_byte,
  input  logic                                cfg_we,
  input  logic [glzw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glzw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  glzw_pkg::cmd_t                      cmd,
  output glzw_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_pixel,
  output logic                                out_line_end,
  output logic                                out_last,
  output logic [1:0]                          out_status
);
  import glzw_pkg::*;

  logic [3:0]            mcs_r;
  logic [15:0]           lw_r;
  logic [CODE_W-1:0]     nfc_r, prev_r;
  logic [3:0]            cw_r;
  logic [13:0]           wl_r;
  logic [BUF_W-1:0]      buf_r;
  logic [BCNT_W-1:0]     cnt_r;
  logic [7:0]            rem_r;
  logic [15:0]           col_r;
  logic                  done_r;
  logic [CODE_W-1:0]     depth_r;
  logic [NCNT_W-1:0]     n_r;
  logic [1:0]            pend_r;
  logic                  kwk_r;
  logic [TBL_AW-1:0]     code_r, walk_x_r;
  logic [7:0]            root_r;
  logic                  hold_valid_r, hold_le_r;
  logic [7:0]            hold_pix_r;
  logic [1:0]            hold_st_r;
  logic                  out_valid_r, out_le_r, out_last_r;
  logic [7:0]            out_pix_r;
  logic [1:0]            out_st_r;

  logic [TBL_AW-1:0]     prefix_mem [TABLE_ENTRIES];
  logic [7:0]            suffix_mem [TABLE_ENTRIES];
  logic [7:0]            stack_mem  [TABLE_ENTRIES];
  logic [TBL_AW-1:0]     prefix_q;
  logic [7:0]            suffix_q, stack_q;

  logic [3:0]            m, mn;
  logic [CODE_W-1:0]     clr_val, end_code, first_new, c13, nfc_nxt;
  logic [TBL_AW-1:0]     c;
  logic                  kwk, code_ok, is_clear, is_end, prev_none, tbl_add;
  logic                  restart, out_free, emit, walk_term;
  logic                  stk_we;
  logic [TBL_AW-1:0]     stk_waddr;
  logic [7:0]            stk_wdata, new_pix;
  logic [16:0]           col_inc;
  logic                  le, new_le;
  logic [1:0]            new_st;

  assign m          = eff_min(mcs_r);
  assign restart    = cfg_we && (cfg_index == CFG_MIN_CODE);
  assign mn         = rst_n ? eff_min(cfg_data[3:0]) : 4'd8;
  assign clr_val    = CODE_W'(1) << m;
  assign end_code   = clr_val + CODE_W'(1);
  assign first_new  = clr_val + CODE_W'(2);

  assign c         = TBL_AW'(buf_r & ((BUF_W'(1) << cw_r) - BUF_W'(1)));
  assign c13       = {1'b0, c};
  assign prev_none = (prev_r == NO_CODE);
  assign tbl_add   = !prev_none && (nfc_r < CODE_W'(TABLE_ENTRIES));
  assign kwk       = tbl_add && (c13 == nfc_r);
  assign is_clear  = (c13 == clr_val);
  assign is_end    = (c13 == end_code);
  assign code_ok   = prev_none ? (c13 < clr_val)
                   : ((c13 < clr_val) || (c13 > end_code && c13 < nfc_r) || kwk);
  assign nfc_nxt   = tbl_add ? nfc_r + CODE_W'(1) : nfc_r;
  assign walk_term = ({1'b0, walk_x_r} < first_new);

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cmd.pop_emit || cmd.stat_emit;
  assign col_inc  = {1'b0, col_r} + 17'd1;
  assign le       = (col_inc >= {1'b0, lw_r});
  assign new_pix  = cmd.pop_emit ? stack_q : 8'd0;
  assign new_le   = cmd.pop_emit && le;
  assign new_st   = cmd.pop_emit ? ST_PIXEL : pend_r;

  always_comb begin
    sts            = '0;
    sts.image_done = done_r;
    sts.pop_ok     = (depth_r != '0) && (n_r != MAX_PIX);
    sts.stop       = (depth_r != '0) || (cnt_r < {1'b0, cw_r});
    sts.code_clear = is_clear;
    sts.code_end   = is_end;
    sts.code_bad   = !is_clear && !is_end && !code_ok;
    sts.walk_term  = walk_term;
    sts.emit_ok    = !hold_valid_r || out_free;
    sts.out_free   = out_free;
    sts.hold_valid = hold_valid_r;
    sts.pend_nz    = (pend_r != ST_PIXEL);
  end

  // string table: one write at insert, one read per chain step
  always_ff @(posedge clk) begin
    if (cmd.walk_end && tbl_add) begin
      prefix_mem[nfc_r[TBL_AW-1:0]] <= prev_r[TBL_AW-1:0];
      suffix_mem[nfc_r[TBL_AW-1:0]] <= root_r;
    end
    if (cmd.walk_rd) begin
      prefix_q <= prefix_mem[walk_x_r];
      suffix_q <= suffix_mem[walk_x_r];
    end
  end

  // KwKwK: slot 0 is reserved during the walk and filled with the root at the end
  assign stk_we    = (cmd.walk_rd && walk_term) || cmd.walk_dt || (cmd.walk_end && kwk_r);
  assign stk_waddr = cmd.walk_end ? '0 : depth_r[TBL_AW-1:0];
  assign stk_wdata = cmd.walk_rd ? walk_x_r[7:0] : (cmd.walk_dt ? suffix_q : root_r);

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (cmd.pop_rd) stack_q <= stack_mem[TBL_AW'(depth_r - CODE_W'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) lw_r <= 16'd640;
    else if (cfg_we && cfg_index == CFG_LINE_WIDTH) lw_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      mcs_r        <= rst_n ? cfg_data[3:0] : 4'd8;
      nfc_r        <= (CODE_W'(1) << mn) + CODE_W'(2);
      cw_r         <= mn + 4'd1;
      wl_r         <= 14'd1 << (mn + 4'd1);
      prev_r       <= NO_CODE;
      buf_r        <= '0;
      cnt_r        <= '0;
      rem_r        <= '0;
      col_r        <= '0;
      done_r       <= 1'b0;
      depth_r      <= '0;
      n_r          <= '0;
      pend_r       <= ST_PIXEL;
      hold_valid_r <= 1'b0;
    end else begin
      if (cmd.byte_in && !done_r) begin
        n_r <= '0;
        if (rem_r == 8'd0) begin
          if (in_data_byte == 8'd0) pend_r <= ST_DONE;
          else begin
            pend_r <= ST_PIXEL;
            rem_r  <= in_data_byte;
          end
        end else begin
          rem_r <= rem_r - 8'd1;
          if (cnt_r > BCNT_W'(BUF_W - 8)) pend_r <= ST_BROKEN;
          else begin
            pend_r <= ST_PIXEL;
            buf_r  <= buf_r | (BUF_W'(in_data_byte) << cnt_r);
            cnt_r  <= cnt_r + BCNT_W'(8);
          end
        end
      end
      if (cmd.take_code) begin
        buf_r <= buf_r >> cw_r;
        cnt_r <= cnt_r - {1'b0, cw_r};
        if (is_clear) begin
          nfc_r  <= first_new;
          cw_r   <= m + 4'd1;
          wl_r   <= 14'd1 << (m + 4'd1);
          prev_r <= NO_CODE;
        end else if (is_end) begin
          if (pend_r == ST_PIXEL) pend_r <= ST_DONE;
        end else if (!code_ok) begin
          pend_r <= ST_BROKEN;
        end else begin
          kwk_r    <= kwk;
          code_r   <= c;
          walk_x_r <= kwk ? prev_r[TBL_AW-1:0] : c;
          depth_r  <= kwk ? CODE_W'(1) : '0;
        end
      end
      if (cmd.walk_rd && walk_term) begin
        depth_r <= depth_r + CODE_W'(1);
        root_r  <= walk_x_r[7:0];
      end
      if (cmd.walk_dt) begin
        depth_r  <= depth_r + CODE_W'(1);
        walk_x_r <= prefix_q;
      end
      if (cmd.walk_end) begin
        nfc_r  <= nfc_nxt;
        prev_r <= {1'b0, code_r};
        if ({1'b0, nfc_nxt} >= wl_r && cw_r < 4'(MAX_CODE_BITS)) begin
          cw_r <= cw_r + 4'd1;
          wl_r <= wl_r << 1;
        end
      end
      if (cmd.pop_rd) depth_r <= depth_r - CODE_W'(1);
      if (cmd.pop_emit) begin
        n_r   <= n_r + NCNT_W'(1);
        col_r <= le ? 16'd0 : col_inc[15:0];
      end
      if (cmd.stat_emit) begin
        done_r  <= 1'b1;
        depth_r <= '0;
      end
      if (emit) hold_valid_r <= 1'b1;
      else if (cmd.flush) hold_valid_r <= 1'b0;
    end
  end

  // hold stage keeps one result back so the final one of a byte can carry last
  always_ff @(posedge clk) begin
    if (emit) begin
      hold_pix_r <= new_pix;
      hold_le_r  <= new_le;
      hold_st_r  <= new_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if ((emit && hold_valid_r) || cmd.flush) out_valid_r <= 1'b1;
    else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if ((emit && hold_valid_r) || cmd.flush) begin
      out_pix_r  <= hold_pix_r;
      out_le_r   <= hold_le_r;
      out_st_r   <= hold_st_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel    = out_pix_r;
  assign out_line_end = out_le_r;
  assign out_last     = out_last_r;
  assign out_status   = out_st_r;

endmodule

// ===== hw/rtl/gif_lzw_decoder.sv =====
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// GIF image-data LZW decoder, 2 to 12 bit codes, pixel and status output.
// ----------------------------------------------------------------------------
// Input: one stream byte per word on in_valid/in_stall (length bytes included).
// Output: pixel, line_end, last, status words on out_valid/out_stall; last
// marks the final word caused by an input byte, status 1/2 ends the image.
// cfg_we writes min_code_size (index 0, restarts the decoder) or line_width
// (index 1); write only while the block is idle.
// A byte completing no code passes accept, decode check, finish and flush. A
// code takes a decode step, a read and a data step per table entry on its
// prefix chain (registered read of the string table feeds the next address),
// a root read and an insert; a pixel takes a check, a registered stack read
// and an emit. Finish and flush close each byte up to the image end. At most
// 63 pixels leave per byte; the rest stay stacked for later bytes.
// A result is held one stage back so that last can be set; in_stall falls
// once the final word reaches the output register, even if it is stalled.
// A stalled receiver freezes the decoder when the output and hold stages
// are full. Reset is synchronous; the tables need no clearing pass.
// ----------------------------------------------------------------------------
`include "gif_lzw_decoder_defines.svh"

module gif_lzw_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_pixel,
  output logic                              out_line_end,
  output logic                              out_last,
  output logic [1:0]                        out_status,
  input  logic                              cfg_we,
  input  logic [glzw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [glzw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import glzw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  glzw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  glzw_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel),
    .out_line_end (out_line_end),
    .out_last     (out_last),
    .out_status   (out_status)
  );

  `GLZW_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
  `GLZW_ASSERT_NXT(a_stat_done, cmd.stat_emit, sts.image_done, "status sent but image not done")
  `GLZW_ASSERT_IMP(a_status_blank, out_valid && out_status != ST_PIXEL, out_pixel == 8'd0 && !out_line_end && out_last, "status word malformed")

endmodule
